// File: sv/tbbpt_pkg.sv
// Package for the two-bit branch predictor table.
// Holds the counter state encoding, widths and the state transition function.
// No dependencies.
`default_nettype none

package tbbpt_pkg;

   localparam int DEFAULT_MAX_INDEX_BITS = 12;
   localparam int COUNT_W = 32;
   localparam int ADDR_W = 32;
   localparam int INDEX_BITS_W = 4;
   localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RESET = 4'd1;

   typedef enum logic [1:0] {
      ST_STRONG_NT = 2'd0,
      ST_WEAK_NT = 2'd1,
      ST_WEAK_T = 2'd2,
      ST_STRONG_T = 2'd3
   } ctr_state_type;

   // Hysteresis variant: both weak states jump to the strong state of the outcome.
   function automatic ctr_state_type next_state(ctr_state_type s, logic taken);
      ctr_state_type r;
      case (s)
         ST_STRONG_T: begin
            r = taken ? ST_STRONG_T : ST_WEAK_T;
         end
         ST_WEAK_T: begin
            r = taken ? ST_STRONG_T : ST_STRONG_NT;
         end
         ST_WEAK_NT: begin
            r = taken ? ST_STRONG_T : ST_STRONG_NT;
         end
         default: begin
            r = taken ? ST_WEAK_NT : ST_STRONG_NT;
         end
      endcase
      return r;
   endfunction

   function automatic logic predicts_taken(ctr_state_type s);
      return (s == ST_WEAK_T) || (s == ST_STRONG_T);
   endfunction

endpackage

`default_nettype wire

// File: sv/two_bit_branch_predictor_table.sv
// An item is registered in the read stage, then its result in the rsp registers.
// Throughput: one item per cycle unless rsp stalls; the table is a one-port-read,
// one-port-write memory with registered reads; the last write is forwarded to s1.
// Reset: synchronous. After reset the table is cleared to strong-taken across all
// 2**MAX_INDEX_BITS entries (4096 by default) with req_ready low; csr writes work.
// Depends on tbbpt_pkg.
`default_nettype none

module two_bit_branch_predictor_table #(
   parameter int MAX_INDEX_BITS = tbbpt_pkg::DEFAULT_MAX_INDEX_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tbbpt_pkg::INDEX_BITS_W-1:0]   csr_index_bits,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tbbpt_pkg::ADDR_W-1:0]         req_branch_address,
   input  wire logic                                 req_actual_taken,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_predicted_taken,
   output logic                                      rsp_mispredicted,
   output logic [tbbpt_pkg::COUNT_W-1:0]             rsp_prediction_total,
   output logic [tbbpt_pkg::COUNT_W-1:0]             rsp_miss_total
);

   import tbbpt_pkg::*;

   localparam int AW = MAX_INDEX_BITS;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [1:0] {
      PH_CLEAR = 2'b01,
      PH_RUN = 2'b10
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [INDEX_BITS_W-1:0] cfg_index_bits_ff, cfg_index_bits_in;

   ctr_state_type table_mem [DEPTH];

   // Read stage.
   logic s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_idx_ff;
   logic s1_taken_ff;
   logic s1_use_ff;
   ctr_state_type rd_state_ff;

   // Most recent table write, for forwarding.
   logic fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_idx_ff;
   ctr_state_type fwd_state_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pred_ff;
   logic rsp_miss_ff;
   logic [COUNT_W-1:0] pred_count_ff, pred_count_in;
   logic [COUNT_W-1:0] miss_count_ff, miss_count_in;

   logic req_fire;
   logic s1_adv;
   logic [AW-1:0] idx_mask;
   logic [AW-1:0] req_idx;
   logic req_use;
   ctr_state_type cur_state;
   ctr_state_type new_state;
   logic cur_pred;
   logic cur_miss;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   ctr_state_type wr_data;
   logic item_wr;

   assign csr_ready = 1'b1;
   assign cfg_index_bits_in = (csr_valid && csr_ready) ? csr_index_bits : cfg_index_bits_ff;

   // A register value above the table size selects all index bits.
   always_comb begin
      for (int i = 0; i < AW; i++) begin
         idx_mask[i] = (i < int'(cfg_index_bits_ff));
      end
   end

   assign req_idx = req_branch_address[AW-1:0] & idx_mask;
   assign req_use = (cfg_index_bits_ff != '0);

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (phase_ff == PH_RUN) && (!s1_valid_ff || s1_adv);
   assign req_fire = req_valid && req_ready;

   assign cur_state = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_state_ff : rd_state_ff;
   assign new_state = next_state(cur_state, s1_taken_ff);
   assign cur_pred = s1_use_ff ? predicts_taken(cur_state) : 1'b1;
   assign cur_miss = cur_pred != s1_taken_ff;
   assign item_wr = s1_adv && s1_use_ff;

   always_comb begin
      phase_in = phase_ff;
      clr_addr_in = clr_addr_ff;
      case (phase_ff)
         PH_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            clr_addr_in = '0;
         end
         default: begin
            phase_in = PH_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_comb begin
      if (phase_ff == PH_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = ST_STRONG_T;
      end else begin
         wr_en = item_wr;
         wr_addr = s1_idx_ff;
         wr_data = new_state;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      pred_count_in = pred_count_ff;
      miss_count_in = miss_count_ff;
      if (item_wr) begin
         if (pred_count_ff != '1) begin
            pred_count_in = pred_count_ff + COUNT_W'(1);
         end
         if (cur_miss && (miss_count_ff != '1)) begin
            miss_count_in = miss_count_ff + COUNT_W'(1);
         end
      end

      fwd_valid_in = fwd_valid_ff || item_wr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_state_ff <= table_mem[req_idx];
         s1_idx_ff <= req_idx;
         s1_taken_ff <= req_actual_taken;
         s1_use_ff <= req_use;
      end
      if (item_wr) begin
         fwd_idx_ff <= s1_idx_ff;
         fwd_state_ff <= new_state;
      end
      if (s1_adv) begin
         rsp_pred_ff <= cur_pred;
         rsp_miss_ff <= cur_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CLEAR;
         clr_addr_ff <= '0;
         cfg_index_bits_ff <= INDEX_BITS_RESET;
         s1_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pred_count_ff <= '0;
         miss_count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         clr_addr_ff <= clr_addr_in;
         cfg_index_bits_ff <= cfg_index_bits_in;
         s1_valid_ff <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pred_count_ff <= pred_count_in;
         miss_count_ff <= miss_count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_mispredicted = rsp_miss_ff;
   assign rsp_prediction_total = pred_count_ff;
   assign rsp_miss_total = miss_count_ff;

   // Every miss is also a prediction, and both counters saturate.
   a_miss_le_pred: assert property (@(posedge clock) disable iff (reset)
      miss_count_ff <= pred_count_ff)
      else $error("miss count exceeds prediction count");

   a_pred_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> pred_count_ff >= $past(pred_count_ff))
      else $error("prediction count decreased");

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLEAR) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("item in flight during table clear");

   a_count_only_on_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (pred_count_ff != $past(pred_count_ff)) |-> rsp_valid_ff)
      else $error("prediction count changed without a result");

endmodule

`default_nettype wire
